FILE: rtl/fls_pkg.sv
// shared types and constants for the fixed length signature matcher
// no dependencies
`default_nettype none

package fls_pkg;

    localparam int NUM_SIGS_DEF  = 6;
    localparam int SIG_LEN_DEF   = 50;
    localparam int POS_WIDTH_DEF = 32;

    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 3;
    localparam int OFF_W    = 6;
    localparam int OFFSET_W = 32;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic [OFFSET_W-1:0] match_offset;
        logic                detected;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/fls_cell.sv
// one window cell: a window byte plus the signature bytes for its position
// depends on fls_pkg
`default_nettype none

module fls_cell #(
    parameter int NUM_SIGS = fls_pkg::NUM_SIGS_DEF
) (
    input  wire                          i_clk,
    input  wire fls_pkg::t_cell_ctl      i_ctl,
    input  wire [NUM_SIGS-1:0]           i_load_sel,
    input  wire [fls_pkg::BYTE_W-1:0]    i_load_data,
    input  wire [fls_pkg::BYTE_W-1:0]    i_byte,
    output logic [fls_pkg::BYTE_W-1:0]   o_byte,
    output logic [NUM_SIGS-1:0]          o_eq
);

    logic [fls_pkg::BYTE_W-1:0] r_byte;
    logic [fls_pkg::BYTE_W-1:0] r_sig [NUM_SIGS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
        for (int s = 0; s < NUM_SIGS; s++) begin
            if (i_ctl.load && i_load_sel[s]) begin
                r_sig[s] <= i_load_data;
            end
        end
    end

    // compare the byte entering this cell
    always_comb begin
        for (int s = 0; s < NUM_SIGS; s++) begin
            o_eq[s] = (i_byte == r_sig[s]);
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

FILE: rtl/fls_skid.sv
// two-entry result buffer between the scan logic and the output stream
// depends on fls_pkg
`default_nettype none

module fls_skid (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wire fls_pkg::t_result  i_data,
    output logic                   o_room,
    output logic                   o_valid,
    output fls_pkg::t_result       o_data,
    input  wire                    i_ready
);

    logic             r_ov;
    logic             r_sv;
    fls_pkg::t_result r_od;
    fls_pkg::t_result r_sd;
    logic             w_pop;

    assign w_pop = r_ov & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_pop) begin
                r_sv <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_ov || w_pop) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (w_pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_pop) begin
                r_od <= r_sd;
            end
        end else if (i_push) begin
            if (!r_ov || w_pop) begin
                r_od <= i_data;
            end else begin
                r_sd <= i_data;
            end
        end
    end

    assign o_room  = ~r_sv;
    assign o_valid = r_ov;
    assign o_data  = r_od;

endmodule

`default_nettype wire

FILE: rtl/fixed_length_signature_matcher.sv
// top level of the fixed length signature matcher: cell row, counters, result buffer
// depends on fls_pkg, fls_cell, fls_skid
`default_nettype none

// Takes one input word per clock, both signature loads and buffer bytes, with no
// bubbles while the result buffer has room. A row of SIG_LEN cells holds the
// sliding window and, per cell, the signature bytes for that position; the window,
// with the byte entering the row, is compared against all signatures at once, and
// the per-cell results are ANDed into one hit per signature. The result for a
// buffer is registered into a two-entry buffer when its last byte is taken, so
// input stalls only when two results wait. The signature store lives in cell
// flops, needs no clearing pass, and must be loaded fully before scanning.
module fixed_length_signature_matcher #(
    parameter int NUM_SIGS  = fls_pkg::NUM_SIGS_DEF,
    parameter int SIG_LEN   = fls_pkg::SIG_LEN_DEF,
    parameter int POS_WIDTH = fls_pkg::POS_WIDTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire                            i_cfg_wdata,    // scan_enable
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire [fls_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // data_byte, sig_index, sig_offset
    input  wire [0:0]                      s_axis_tuser,   // op
    input  wire                            s_axis_tlast,   // last_byte
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [fls_pkg::M_TDATA_W-1:0]  m_axis_tdata    // detected, match_offset
);

    localparam int FILL_W = $clog2(SIG_LEN + 1);
    localparam int OW     = fls_pkg::OFFSET_W;
    localparam int BW     = fls_pkg::BYTE_W;
    localparam int IW     = fls_pkg::IDX_W;

    logic                 r_scan_en;
    logic [FILL_W-1:0]    r_fill;
    logic [POS_WIDTH-1:0] r_pos;
    logic                 r_found;
    logic [POS_WIDTH-1:0] r_off;

    logic                 w_acc;
    logic                 w_scan;
    logic                 w_load;
    logic [BW-1:0]        w_data;
    logic [IW-1:0]        w_idx;
    logic [fls_pkg::OFF_W-1:0] w_soff;
    logic [NUM_SIGS-1:0]  w_sel;
    logic [NUM_SIGS-1:0]  w_eq [SIG_LEN];
    logic [BW-1:0]        w_link [1:SIG_LEN];
    logic [NUM_SIGS-1:0]  w_match;
    logic                 w_full;
    logic                 w_hit;
    logic [POS_WIDTH-1:0] w_new_off;
    logic [POS_WIDTH-1:0] w_off_sel;
    logic [OW-1:0]        w_off32;
    logic                 w_det;
    logic                 w_push;
    fls_pkg::t_result     w_res;
    fls_pkg::t_result     w_out;

    assign w_acc  = s_axis_tvalid & s_axis_tready;
    assign w_scan = w_acc & (s_axis_tuser[0] == fls_pkg::OP_SCAN);
    assign w_load = w_acc & (s_axis_tuser[0] == fls_pkg::OP_LOAD);
    assign w_data = s_axis_tdata[BW-1:0];
    assign w_idx  = s_axis_tdata[BW+IW-1:BW];
    assign w_soff = s_axis_tdata[BW+IW+fls_pkg::OFF_W-1:BW+IW];

    assign w_link[SIG_LEN] = w_data;

    for (genvar s = 0; s < NUM_SIGS; s++) begin : g_sel
        assign w_sel[s] = ({3'b000, w_idx} == 6'(s));
    end

    for (genvar i = 0; i < SIG_LEN; i++) begin : g_cell
        fls_pkg::t_cell_ctl w_ctl;
        assign w_ctl.shift = w_scan;
        assign w_ctl.load  = w_load & (w_soff == fls_pkg::OFF_W'(i));
        if (i == 0) begin : g_head
            fls_cell #(.NUM_SIGS(NUM_SIGS)) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_load_sel  (w_sel),
                .i_load_data (w_data),
                .i_byte      (w_link[i+1]),
                .o_byte      (),
                .o_eq        (w_eq[i])
            );
        end else begin : g_body
            fls_cell #(.NUM_SIGS(NUM_SIGS)) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_load_sel  (w_sel),
                .i_load_data (w_data),
                .i_byte      (w_link[i+1]),
                .o_byte      (w_link[i]),
                .o_eq        (w_eq[i])
            );
        end
    end

    always_comb begin
        w_match = '1;
        for (int i = 0; i < SIG_LEN; i++) begin
            w_match = w_match & w_eq[i];
        end
    end

    assign w_full    = (r_fill >= FILL_W'(SIG_LEN - 1));
    assign w_hit     = w_full & ~r_found & (|w_match);
    assign w_new_off = r_pos - POS_WIDTH'(SIG_LEN - 1);
    assign w_off_sel = r_found ? r_off : w_new_off;
    assign w_det     = r_scan_en & (r_found | w_hit);

    if (POS_WIDTH >= OW) begin : g_trunc
        assign w_off32 = w_off_sel[OW-1:0];
    end else begin : g_ext
        assign w_off32 = {{(OW - POS_WIDTH){1'b0}}, w_off_sel};
    end

    assign w_push             = w_scan & s_axis_tlast;
    assign w_res.detected     = w_det;
    assign w_res.match_offset = w_det ? w_off32 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_en <= 1'b0;
            r_fill    <= '0;
            r_pos     <= '0;
            r_found   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_scan_en <= i_cfg_wdata;
            end
            if (w_scan) begin
                if (s_axis_tlast) begin
                    r_fill  <= '0;
                    r_pos   <= '0;
                    r_found <= 1'b0;
                end else begin
                    if (r_fill != FILL_W'(SIG_LEN)) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    if (r_pos != '1) begin
                        r_pos <= r_pos + POS_WIDTH'(1);
                    end
                    if (w_hit) begin
                        r_found <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan && !s_axis_tlast && w_hit) begin
            r_off <= w_new_off;
        end
    end

    fls_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_room  (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {{(fls_pkg::M_TDATA_W - OW - 1){1'b0}}, w_out.match_offset,
                           w_out.detected};

endmodule

`default_nettype wire

FILE: rtl/fls_checker.sv
// port-level checks for the fixed length signature matcher, bound to the top level
// depends on fls_pkg and fixed_length_signature_matcher
`default_nettype none

module fls_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            s_axis_tvalid,
    input wire                            s_axis_tready,
    input wire [0:0]                      s_axis_tuser,
    input wire                            s_axis_tlast,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [fls_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    // input stalls only while results are backed up
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

    // a fresh result follows an accepted last scan word
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tlast
                  && (s_axis_tuser[0] == fls_pkg::OP_SCAN)))
        else $error("result without a last scan word");

    // offset is zero when nothing was detected
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[32:1] == 32'd0))
        else $error("offset nonzero without detection");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind fixed_length_signature_matcher fls_checker u_fls_checker (.*);

`default_nettype wire

FILE: tb/tb_fixed_length_signature_matcher.sv
// self-checking testbench for fixed_length_signature_matcher: stream stimulus,
// a scoreboard class that tracks the window and store, and checks every report word
// depends on fls_pkg and the fixed_length_signature_matcher rtl
`default_nettype none

module tb_fixed_length_signature_matcher;

    localparam int N_SIGS      = fls_pkg::NUM_SIGS_DEF;
    localparam int SIG_BYTES   = fls_pkg::SIG_LEN_DEF;
    localparam int IN_PAD_W    = fls_pkg::S_TDATA_W - fls_pkg::BYTE_W - fls_pkg::IDX_W
                                 - fls_pkg::OFF_W;
    localparam int CYCLE_LIMIT = 400000;

    class scan_scoreboard;
        bit [7:0]         sig_bytes [N_SIGS][SIG_BYTES];
        bit [7:0]         window [SIG_BYTES];
        int               fill;
        bit [31:0]        position;
        bit               found;
        bit [31:0]        found_at;
        bit               enable;
        fls_pkg::t_result pending_reports [$];
        int               errors;
        int               reports_seen;

        function void clear_scan();
            foreach (window[k]) window[k] = 8'h00;
            fill     = 0;
            position = '0;
            found    = 1'b0;
            found_at = '0;
        endfunction

        function bit window_hits();
            bit same;
            for (int s = 0; s < N_SIGS; s++) begin
                same = 1'b1;
                for (int k = 0; k < SIG_BYTES; k++) begin
                    if (window[k] != sig_bytes[s][k]) same = 1'b0;
                end
                if (same) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_word(bit op, bit [7:0] data, bit last, bit [2:0] idx, bit [5:0] off);
            fls_pkg::t_result r;
            if (op == fls_pkg::OP_LOAD) begin
                if (idx < N_SIGS && off < SIG_BYTES) sig_bytes[idx][off] = data;
                return;
            end
            for (int k = 0; k < SIG_BYTES - 1; k++) window[k] = window[k + 1];
            window[SIG_BYTES - 1] = data;
            if (fill < SIG_BYTES) fill++;
            if (fill >= SIG_BYTES && !found && window_hits()) begin
                found    = 1'b1;
                found_at = position - (SIG_BYTES - 1);
            end
            // position saturates
            if (position != '1) position++;
            if (last) begin
                r.detected     = enable && found;
                r.match_offset = r.detected ? found_at : '0;
                pending_reports.push_back(r);
                clear_scan();
            end
        endfunction

        function void log_mismatch(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_report(logic [fls_pkg::M_TDATA_W-1:0] word);
            fls_pkg::t_result got;
            fls_pkg::t_result want;
            got = word[$bits(fls_pkg::t_result)-1:0];
            reports_seen++;
            if (pending_reports.size() == 0) begin
                log_mismatch($sformatf("unexpected report word %h", word));
                return;
            end
            want = pending_reports.pop_front();
            if (got.detected !== want.detected)
                log_mismatch($sformatf("report %0d detected: expected %b, got %b",
                                       reports_seen, want.detected, got.detected));
            if (got.match_offset !== want.match_offset)
                log_mismatch($sformatf("report %0d match_offset: expected %0d, got %0d",
                                       reports_seen, want.match_offset, got.match_offset));
        endfunction
    endclass

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic                          i_cfg_wdata   = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic [fls_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;   // data_byte, sig_index, sig_offset
    logic [0:0]                    s_axis_tuser  = '0;   // op
    logic                          s_axis_tlast  = 1'b0; // last_byte
    logic                          m_axis_tready = 1'b0;
    wire                           s_axis_tready;
    wire                           m_axis_tvalid;
    wire  [fls_pkg::M_TDATA_W-1:0] m_axis_tdata;         // detected, match_offset

    scan_scoreboard sb;
    int             cycle_count = 0;
    int             words_sent  = 0;
    int             hold_left   = 0;
    bit             send_gaps   = 1'b1;
    bit             recv_gaps   = 1'b1;
    bit             calm        = 1'b0;

    fixed_length_signature_matcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** fixed_length_signature_matcher: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) sb.check_report(m_axis_tdata);
    end

    // receiver: long hold-off, random stall bursts, or ready
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready = 1'b0;
            end else if (recv_gaps && $urandom_range(0, 9) == 0) begin
                stall_left    = $urandom_range(1, 12) - 1;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    task drive_word(bit op, bit [7:0] data, bit last, bit [2:0] idx, bit [5:0] off);
        int gap;
        if (send_gaps && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tlast  = last;
        s_axis_tdata  = {{IN_PAD_W{1'b0}}, off, idx, data};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.take_word(op, data, last, idx, off);
        words_sent++;
    endtask

    task send_random_load();
        drive_word(fls_pkg::OP_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
    endtask

    task wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_scan_enable(bit value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        sb.enable   = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task send_bytes(bit [7:0] bytes_q [$]);
        for (int i = 0; i < bytes_q.size(); i++) begin
            if ($urandom_range(0, 49) == 0) send_random_load();
            drive_word(fls_pkg::OP_SCAN, bytes_q[i], i == bytes_q.size() - 1,
                       3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
        end
    endtask

    task send_signature_buffer(int s, int len);
        bit [7:0] bytes_q [$];
        for (int k = 0; k < len; k++) bytes_q.push_back(sb.sig_bytes[s][k]);
        send_bytes(bytes_q);
    endtask

    task send_random_buffer();
        bit [7:0] bytes_q [$];
        int       kind;
        int       s;
        int       start;
        int       n;
        kind = $urandom_range(0, 99);
        s    = $urandom_range(0, N_SIGS - 1);
        if (!calm) begin
            if ($urandom_range(0, 7) == 0) send_gaps = !send_gaps;
            if ($urandom_range(0, 7) == 0) recv_gaps = !recv_gaps;
        end
        if (kind < 60) begin
            // embedded signature, sometimes a second one later, sometimes one byte off
            repeat ($urandom_range(0, 20)) bytes_q.push_back(8'($urandom_range(0, 255)));
            start = bytes_q.size();
            for (int k = 0; k < SIG_BYTES; k++) bytes_q.push_back(sb.sig_bytes[s][k]);
            if (kind >= 45) begin
                n = start + $urandom_range(0, SIG_BYTES - 1);
                bytes_q[n] = bytes_q[n] ^ 8'($urandom_range(1, 255));
            end
            repeat ($urandom_range(0, 12)) bytes_q.push_back(8'($urandom_range(0, 255)));
            if (kind < 10) begin
                s = $urandom_range(0, N_SIGS - 1);
                for (int k = 0; k < SIG_BYTES; k++) bytes_q.push_back(sb.sig_bytes[s][k]);
            end
        end else if (kind < 80) begin
            // short buffer, often a cut-off signature
            n = $urandom_range(1, SIG_BYTES - 1);
            for (int k = 0; k < n; k++)
                bytes_q.push_back(kind < 70 ? sb.sig_bytes[s][k] : 8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(SIG_BYTES, 90)) bytes_q.push_back(8'($urandom_range(0, 255)));
        end
        send_bytes(bytes_q);
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_random_load();
    endtask

    initial begin
        bit phase_enable [6];
        phase_enable = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        sb = new;
        sb.clear_scan();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_scan_enable(1'b1);
        // fill the whole store before any scan
        for (int s = 0; s < N_SIGS; s++) begin
            for (int k = 0; k < SIG_BYTES; k++) begin
                drive_word(fls_pkg::OP_LOAD,
                           (s == 0 && k == 0) ? 8'h00 :
                           (s == 0 && k == 1) ? 8'hFF : 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 3'(s), 6'(k));
            end
        end

        // out of range loads, last flag on loads
        drive_word(fls_pkg::OP_LOAD, 8'hFF, 1'b1, 3'd6, 6'd0);
        drive_word(fls_pkg::OP_LOAD, 8'h00, 1'b0, 3'd7, 6'd63);
        drive_word(fls_pkg::OP_LOAD, 8'hA5, 1'b1, 3'd0, 6'd50);
        drive_word(fls_pkg::OP_LOAD, 8'h5A, 1'b0, 3'd5, 6'd63);
        // one byte buffer, exact match, one byte short, disabled match
        drive_word(fls_pkg::OP_SCAN, 8'hFF, 1'b1, 3'd7, 6'd63);
        send_signature_buffer(N_SIGS - 1, SIG_BYTES);
        send_signature_buffer(1, SIG_BYTES - 1);
        write_scan_enable(1'b0);
        send_signature_buffer(3, SIG_BYTES);
        write_scan_enable(1'b1);

        // receiver holds off while tiny buffers pile up, then sender waits for all reports
        wait_drained();
        send_gaps = 1'b0;
        hold_left = 400;
        repeat (40) begin
            if ($urandom_range(0, 1) == 0)
                drive_word(fls_pkg::OP_SCAN, 8'($urandom_range(0, 255)), 1'b0, 3'd0, 6'd0);
            drive_word(fls_pkg::OP_SCAN, 8'($urandom_range(0, 255)), 1'b1, 3'd0, 6'd0);
        end
        wait_drained();
        send_gaps = 1'b1;

        words_sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            write_scan_enable(phase_enable[ph]);
            if (ph == 5) begin
                calm      = 1'b1;
                send_gaps = 1'b0;
                recv_gaps = 1'b0;
            end
            while (words_sent < (ph + 1) * 90)
                send_random_buffer();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
            $display("** fixed_length_signature_matcher: PASSED **");
        end else begin
            $display("** fixed_length_signature_matcher: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
